FILE: rtl/radix_digit_converter_assert.svh
//------------------------------------------------------------------------------
// Radix digit converter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rdc_pkg.sv
//------------------------------------------------------------------------------
// Radix digit converter package
// Register codes, character constants, microcode word format and program.
//------------------------------------------------------------------------------
package rdc_pkg;

    // Configuration port widths and register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 6;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RADIX       = 2'd0,
        CFG_FIELD_WIDTH = 2'd1
    } cfg_reg_t;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [4:0] FIELD_WIDTH_RESET = 5'd12;

    localparam logic [6:0] CHAR_SPACE = 7'd32;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    // 'A' minus ten, so that digit ten maps to 'A'.
    localparam logic [6:0] CHAR_ALPHA_BASE = 7'd55;

    // Program counter of the sequencer.
    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE     = 3'd0;
    localparam step_t STEP_DIV_INIT = 3'd1;
    localparam step_t STEP_DIV_BIT  = 3'd2;
    localparam step_t STEP_STORE    = 3'd3;
    localparam step_t STEP_FETCH    = 3'd4;
    localparam step_t STEP_EMIT     = 3'd5;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_IN_VALID  = 3'd1,
        COND_DIV_LAST  = 3'd2,
        COND_MORE      = 3'd3,
        COND_LAST_CHAR = 3'd4
    } cond_t;

    // One control word: datapath strobes, a jump condition and two targets.
    typedef struct packed {
        logic  in_ready;
        logic  div_init;
        logic  div_bit;
        logic  store_digit;
        logic  emit_load;
        logic  wait_out;
        cond_t cond;
        step_t jump;
        step_t next;
    } ucode_t;

    // Control store.
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        w = '{in_ready: 1'b0, div_init: 1'b0, div_bit: 1'b0, store_digit: 1'b0,
              emit_load: 1'b0, wait_out: 1'b0, cond: COND_ALWAYS,
              jump: STEP_IDLE, next: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:
            begin
                w.in_ready = 1'b1;
                w.cond     = COND_IN_VALID;
                w.jump     = STEP_DIV_INIT;
                w.next     = STEP_IDLE;
            end
            STEP_DIV_INIT:
            begin
                w.div_init = 1'b1;
                w.jump     = STEP_DIV_BIT;
            end
            STEP_DIV_BIT:
            begin
                w.div_bit = 1'b1;
                w.cond    = COND_DIV_LAST;
                w.jump    = STEP_STORE;
                w.next    = STEP_DIV_BIT;
            end
            STEP_STORE:
            begin
                w.store_digit = 1'b1;
                w.cond        = COND_MORE;
                w.jump        = STEP_DIV_INIT;
                w.next        = STEP_FETCH;
            end
            STEP_FETCH:
            begin
                w.jump = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.emit_load = 1'b1;
                w.wait_out  = 1'b1;
                w.cond      = COND_LAST_CHAR;
                w.jump      = STEP_IDLE;
                w.next      = STEP_FETCH;
            end
            default:
            begin
                w.jump = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // Digit 0..35 to its ASCII character.
    function automatic logic [6:0] glyph(input logic [5:0] d);
        logic [6:0] c;
        if (d < 6'd10)
        begin
            c = CHAR_ZERO + 7'(d);
        end
        else
        begin
            c = CHAR_ALPHA_BASE + 7'(d);
        end
        return c;
    endfunction

endpackage

FILE: rtl/rdc_if.sv
//------------------------------------------------------------------------------
// Radix digit converter channels
// Valid/ready channels for values, characters and register writes.
//------------------------------------------------------------------------------

// Value request channel.
interface rdc_value_if #(
    parameter int VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// Character request channel.
interface rdc_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

// Register write channel.
interface rdc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rdc_pkg::CFG_INDEX_BITS-1:0] index;
    logic [rdc_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/radix_digit_converter.sv
//------------------------------------------------------------------------------
// Radix digit converter
// Converts an unsigned value to ASCII digits in base 2 to 36, padded with
// trailing spaces to a minimum field width.
//------------------------------------------------------------------------------
// One value is handled at a time. A small microcoded sequencer drives a
// bit-serial restoring divider: each digit takes a setup step, one quotient
// bit per cycle, then a store step, and each output character then takes a
// digit store read and an output load, the load waiting while the output side
// stalls. The last character sits in an output register, so the next value
// is accepted while it waits to be taken. Register writes are taken at any
// time and must be made while idle.
//------------------------------------------------------------------------------
`include "radix_digit_converter_assert.svh"

module radix_digit_converter #(
    parameter int MAX_DIGITS = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rdc_value_if.sink  value_chan,
    rdc_char_if.source char_chan,
    rdc_cfg_if.sink    cfg_chan
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int BW = $clog2(VALUE_BITS);

    // Configuration registers.
    logic [5:0] radix_reg;
    logic [4:0] field_width_reg;

    // Sequencer.
    rdc_pkg::step_t  pc_reg;
    rdc_pkg::step_t  pc_next;
    rdc_pkg::ucode_t ctl;
    logic            cond_true;

    // Datapath.
    logic [VALUE_BITS-1:0] quot_reg;
    logic [5:0]            rem_reg;
    logic [BW-1:0]         bit_cnt_reg;
    logic [CW-1:0]         digit_count_reg;
    logic [CW-1:0]         emit_index_reg;
    logic [5:0]            digit_store [MAX_DIGITS];
    logic [5:0]            rd_data_reg;

    // Output register.
    logic       out_valid_reg;
    logic [6:0] char_reg;
    logic       last_reg;

    logic             in_accept;
    logic             out_free;
    logic             emit_go;
    logic [6:0]       trial;
    logic             trial_ge;
    logic [CW-1:0]    width_clamped;
    logic [CW-1:0]    total;
    logic             is_last;
    logic             more_digits;
    logic [CW-1:0]    rd_diff;
    logic [AW-1:0]    rd_addr;

    // Register writes, with the base saturated into range.
    assign cfg_chan.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= rdc_pkg::RADIX_RESET;
            field_width_reg <= rdc_pkg::FIELD_WIDTH_RESET;
        end
        else if (cfg_chan.valid)
        begin
            if (cfg_chan.index == rdc_pkg::CFG_RADIX)
            begin
                priority if (cfg_chan.data < rdc_pkg::RADIX_MIN)
                begin
                    radix_reg <= rdc_pkg::RADIX_MIN;
                end
                else if (cfg_chan.data > rdc_pkg::RADIX_MAX)
                begin
                    radix_reg <= rdc_pkg::RADIX_MAX;
                end
                else
                begin
                    radix_reg <= cfg_chan.data;
                end
            end
            else if (cfg_chan.index == rdc_pkg::CFG_FIELD_WIDTH)
            begin
                field_width_reg <= cfg_chan.data[4:0];
            end
        end
    end

    // Control word fetch and status used by the jump conditions.
    assign ctl       = rdc_pkg::ucode_rom(pc_reg);
    assign in_accept = ctl.in_ready && value_chan.valid;
    assign value_chan.ready = ctl.in_ready;
    assign out_free  = !out_valid_reg || char_chan.ready;
    assign emit_go   = ctl.emit_load && out_free;

    assign width_clamped = (32'(field_width_reg) > MAX_DIGITS) ? CW'(MAX_DIGITS)
                                                                : CW'(field_width_reg);
    assign total       = (digit_count_reg > width_clamped) ? digit_count_reg : width_clamped;
    assign is_last     = (emit_index_reg + CW'(1)) == total;
    assign more_digits = (quot_reg != '0) && ((32'(digit_count_reg) + 32'd1) < MAX_DIGITS);

    always_comb
    begin
        unique case (ctl.cond)
            rdc_pkg::COND_ALWAYS:    cond_true = 1'b1;
            rdc_pkg::COND_IN_VALID:  cond_true = value_chan.valid;
            rdc_pkg::COND_DIV_LAST:  cond_true = (bit_cnt_reg == '0);
            rdc_pkg::COND_MORE:      cond_true = more_digits;
            rdc_pkg::COND_LAST_CHAR: cond_true = is_last;
            default:                 cond_true = 1'b0;
        endcase
    end

    // Next step: hold while the output is blocked, else branch.
    always_comb
    begin
        priority if (ctl.wait_out && !out_free)
        begin
            pc_next = pc_reg;
        end
        else if (cond_true)
        begin
            pc_next = ctl.jump;
        end
        else
        begin
            pc_next = ctl.next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rdc_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Restoring divider trial subtraction, one quotient bit per cycle.
    assign trial    = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign trial_ge = trial >= {1'b0, radix_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= '0;
            emit_index_reg  <= '0;
            bit_cnt_reg     <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                digit_count_reg <= '0;
                emit_index_reg  <= '0;
            end
            if (ctl.div_init)
            begin
                bit_cnt_reg <= BW'(VALUE_BITS - 1);
            end
            else if (ctl.div_bit)
            begin
                bit_cnt_reg <= bit_cnt_reg - BW'(1);
            end
            if (ctl.store_digit)
            begin
                digit_count_reg <= digit_count_reg + CW'(1);
            end
            if (emit_go)
            begin
                emit_index_reg <= emit_index_reg + CW'(1);
            end
        end
    end

    // Dividend/quotient and remainder.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            quot_reg <= value_chan.value;
        end
        else if (ctl.div_bit)
        begin
            quot_reg <= {quot_reg[VALUE_BITS-2:0], trial_ge};
        end
        if (ctl.div_init)
        begin
            rem_reg <= '0;
        end
        else if (ctl.div_bit)
        begin
            rem_reg <= trial_ge ? 6'(trial - {1'b0, radix_reg}) : trial[5:0];
        end
    end

    // Digit store: least significant digit at entry zero, read back reversed.
    assign rd_diff = digit_count_reg - emit_index_reg - CW'(1);
    assign rd_addr = rd_diff[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.store_digit)
        begin
            digit_store[digit_count_reg[AW-1:0]] <= rem_reg;
        end
        rd_data_reg <= digit_store[rd_addr];
    end

    // Output register: digits first, then padding spaces.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (char_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            char_reg <= (emit_index_reg < digit_count_reg) ? rdc_pkg::glyph(rd_data_reg)
                                                           : rdc_pkg::CHAR_SPACE;
            last_reg <= is_last;
        end
    end

    assign char_chan.valid     = out_valid_reg;
    assign char_chan.character = char_reg;
    assign char_chan.last_char = last_reg;

    // Checks on the sequencer and datapath.
    `RDC_ASSERT_SAME(a_no_overrun, emit_go, emit_index_reg < total, "character past end of run")
    `RDC_ASSERT_SAME(a_store_room, ctl.store_digit, 32'(digit_count_reg) < MAX_DIGITS,
        "digit store overflow")
    `RDC_ASSERT_SAME(a_rem_range, ctl.div_bit || ctl.store_digit, rem_reg < radix_reg,
        "remainder not below base")
    `RDC_ASSERT_NEXT(a_done_idle, emit_go && is_last, pc_reg == rdc_pkg::STEP_IDLE,
        "sequencer did not return to idle after last character")

endmodule
